@@ src/lkt_pkg.sv @@
`timescale 1ns / 1ps

package lkt_pkg;

   // Field widths fixed by the channel formats
   localparam int OP_W      = 2;
   localparam int BYTE_W    = 8;
   localparam int IDX_W     = 6;
   localparam int CODE_W    = 10;
   localparam int SW_W      = 5;

   // Storage defaults
   localparam int KEY_COUNT   = 64;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [IDX_W-1:0] SYM_KEY_RESET = 6'd25;

   // Raw byte layout
   localparam int BIT_SWITCH  = 7;
   localparam int BIT_RELEASE = 6;

   // Item operations
   typedef enum logic [OP_W-1:0] {
      OP_KEY         = 2'd0,
      OP_LOAD_NORMAL = 2'd1,
      OP_LOAD_SYMBOL = 2'd2
   } op_type;

   // Switch codes carried in bits 5..1 of a switch byte
   localparam logic [SW_W-1:0] SW_LID_OPEN   = 5'd3;
   localparam logic [SW_W-1:0] SW_DOCK       = 5'd5;
   localparam logic [SW_W-1:0] SW_LID_TABLET = 5'd6;
   localparam logic [SW_W-1:0] SW_LID_CLOSE  = 5'd7;

   // Switch ids reported in event_code
   localparam logic [CODE_W-1:0] SWID_LID    = 10'd0;
   localparam logic [CODE_W-1:0] SWID_TABLET = 10'd1;
   localparam logic [CODE_W-1:0] SWID_DOCK   = 10'd2;

   // Event kinds
   localparam logic EV_KEY    = 1'b0;
   localparam logic EV_SWITCH = 1'b1;

   // Command kinds passed from front to back
   typedef enum logic [1:0] {
      CMD_KEY         = 2'd0,
      CMD_LOAD_NORMAL = 2'd1,
      CMD_LOAD_SYMBOL = 2'd2,
      CMD_SWITCH      = 2'd3
   } cmd_kind_type;

   // One classified command; code holds the map code or the switch id,
   // value holds pressed or switch on, layer the symbol mode at that time
   typedef struct packed {
      cmd_kind_type       kind;
      logic [IDX_W-1:0]   idx;
      logic [CODE_W-1:0]  code;
      logic               value;
      logic               layer;
   } cmd_type;

   // One result word
   typedef struct packed {
      logic              kind;
      logic [CODE_W-1:0] code;
      logic              value;
      logic              last;
   } event_type;

endpackage

@@ src/lkt_if.sv @@
`timescale 1ns / 1ps

// Input channel: raw byte or map load
interface lkt_req_if;
   logic                           valid;
   logic                           ready;
   logic [lkt_pkg::OP_W-1:0]       operation;
   logic [lkt_pkg::BYTE_W-1:0]     key_byte;
   logic [lkt_pkg::IDX_W-1:0]      map_index;
   logic [lkt_pkg::CODE_W-1:0]     map_code;

   modport source (output valid, output operation, output key_byte, output map_index,
                   output map_code, input ready);
   modport sink   (input valid, input operation, input key_byte, input map_index,
                   input map_code, output ready);
endinterface

// Result channel: key or switch event
interface lkt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           event_kind;
   logic [lkt_pkg::CODE_W-1:0]     event_code;
   logic                           event_value;
   logic                           last;

   modport source (output valid, output event_kind, output event_code, output event_value,
                   output last, input ready);
   modport sink   (input valid, input event_kind, input event_code, input event_value,
                   input last, output ready);
endinterface

// Configuration channel: symbol key index
interface lkt_csr_if;
   logic                           valid;
   logic                           ready;
   logic [lkt_pkg::IDX_W-1:0]      data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ src/lkt_ram.sv @@
`timescale 1ns / 1ps

module lkt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/lkt_front.sv @@
`timescale 1ns / 1ps

module lkt_front #(
   parameter int KEY_COUNT = lkt_pkg::KEY_COUNT
) (
   input  logic              clock,
   input  logic              reset,
   lkt_req_if.sink           req_if,
   lkt_csr_if.sink           csr_if,
   input  logic              q_ready,
   output logic              q_push,
   output lkt_pkg::cmd_type  q_cmd
);

   logic [lkt_pkg::IDX_W-1:0] sym_key_ff, sym_key_in;
   logic                      sym_mode_ff, sym_mode_in;
   logic                      lid_closing_ff, lid_closing_in;

   logic                      accept;
   logic [lkt_pkg::SW_W-1:0]  sw_code;
   logic                      sw_on;
   logic [lkt_pkg::IDX_W-1:0] key_idx;
   logic                      key_pressed;
   logic                      key_in_range;
   logic                      load_in_range;

   assign req_if.ready = q_ready;
   assign csr_if.ready = 1'b1;
   assign accept       = req_if.valid && req_if.ready;

   assign sw_code       = req_if.key_byte[lkt_pkg::SW_W:1];
   assign sw_on         = !req_if.key_byte[0];
   assign key_idx       = req_if.key_byte[lkt_pkg::IDX_W-1:0];
   assign key_pressed   = !req_if.key_byte[lkt_pkg::BIT_RELEASE];
   assign key_in_range  = {1'b0, key_idx} < (lkt_pkg::IDX_W + 1)'(KEY_COUNT);
   assign load_in_range = {1'b0, req_if.map_index} < (lkt_pkg::IDX_W + 1)'(KEY_COUNT);

   // Classify the word; switch and symbol-key state resolve here in order
   always_comb begin
      sym_key_in     = sym_key_ff;
      sym_mode_in    = sym_mode_ff;
      lid_closing_in = lid_closing_ff;
      q_push         = 1'b0;
      q_cmd          = '0;

      if (csr_if.valid) begin
         sym_key_in = csr_if.data;
      end

      if (accept) begin
         case (req_if.operation)
            lkt_pkg::OP_KEY: begin
               if (req_if.key_byte[lkt_pkg::BIT_SWITCH]) begin
                  case (sw_code)
                     lkt_pkg::SW_LID_OPEN: begin
                        if (!sw_on) lid_closing_in = 1'b0;
                     end
                     lkt_pkg::SW_LID_CLOSE: begin
                        if (sw_on) lid_closing_in = 1'b1;
                     end
                     lkt_pkg::SW_LID_TABLET: begin
                        q_push     = 1'b1;
                        q_cmd.kind = lkt_pkg::CMD_SWITCH;
                        q_cmd.code = lid_closing_ff ? lkt_pkg::SWID_LID
                                                    : lkt_pkg::SWID_TABLET;
                        q_cmd.value = sw_on;
                     end
                     lkt_pkg::SW_DOCK: begin
                        q_push      = 1'b1;
                        q_cmd.kind  = lkt_pkg::CMD_SWITCH;
                        q_cmd.code  = lkt_pkg::SWID_DOCK;
                        q_cmd.value = sw_on;
                     end
                     default: ;
                  endcase
               end else if (key_idx == sym_key_ff) begin
                  sym_mode_in = key_pressed;
               end else if (key_in_range) begin
                  q_push      = 1'b1;
                  q_cmd.kind  = lkt_pkg::CMD_KEY;
                  q_cmd.idx   = key_idx;
                  q_cmd.value = key_pressed;
                  q_cmd.layer = sym_mode_ff;
               end
            end
            lkt_pkg::OP_LOAD_NORMAL: begin
               q_push     = load_in_range;
               q_cmd.kind = lkt_pkg::CMD_LOAD_NORMAL;
               q_cmd.idx  = req_if.map_index;
               q_cmd.code = req_if.map_code;
            end
            lkt_pkg::OP_LOAD_SYMBOL: begin
               q_push     = load_in_range;
               q_cmd.kind = lkt_pkg::CMD_LOAD_SYMBOL;
               q_cmd.idx  = req_if.map_index;
               q_cmd.code = req_if.map_code;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_key_ff     <= lkt_pkg::SYM_KEY_RESET;
         sym_mode_ff    <= 1'b0;
         lid_closing_ff <= 1'b0;
      end else begin
         sym_key_ff     <= sym_key_in;
         sym_mode_ff    <= sym_mode_in;
         lid_closing_ff <= lid_closing_in;
      end
   end

endmodule

@@ src/lkt_queue.sv @@
`timescale 1ns / 1ps

module lkt_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lkt_pkg::cmd_type  push_cmd,
   output logic              push_ready,
   input  logic              pop,
   output logic              pop_valid,
   output lkt_pkg::cmd_type  pop_cmd
);

   localparam int DEPTH = lkt_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lkt_pkg::cmd_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ src/lkt_back.sv @@
`timescale 1ns / 1ps

module lkt_back #(
   parameter int KEY_COUNT = lkt_pkg::KEY_COUNT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  lkt_pkg::cmd_type  q_cmd,
   output logic              q_pop,
   lkt_rsp_if.source         rsp_if
);

   localparam int AW = $clog2(KEY_COUNT);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DATA   = 3'b010,
      ST_SECOND = 3'b100
   } state_type;

   state_type                   st_ff, st_in;
   logic [AW-1:0]               cur_idx_ff, cur_idx_in;
   logic                        cur_pressed_ff, cur_pressed_in;
   logic                        cur_layer_ff, cur_layer_in;
   lkt_pkg::event_type          pend_ff, pend_in;
   lkt_pkg::event_type          out_ff, out_in;
   logic                        out_vld_ff, out_vld_in;
   logic [KEY_COUNT-1:0]        norm_vld_ff, sym_vld_ff, mark_ff;

   logic [AW-1:0]               q_idx;
   logic [AW-1:0]               rd_addr;
   logic [lkt_pkg::CODE_W-1:0]  norm_rd, sym_rd;
   logic [lkt_pkg::CODE_W-1:0]  norm_code, sym_code;
   logic [lkt_pkg::CODE_W-1:0]  main_code, other_code;
   logic                        active, pre_release;
   logic                        can_emit, emit, free;
   logic                        norm_wr, sym_wr, mark_wr;

   assign q_idx    = q_cmd.idx[AW-1:0];
   assign can_emit = !out_vld_ff || rsp_if.ready;
   assign rd_addr  = (q_pop && q_cmd.kind == lkt_pkg::CMD_KEY) ? q_idx : cur_idx_ff;

   lkt_ram #(.WIDTH(lkt_pkg::CODE_W), .DEPTH(KEY_COUNT)) u_norm_ram (
      .clock   (clock),
      .wr_en   (norm_wr),
      .wr_addr (q_idx),
      .wr_data (q_cmd.code),
      .rd_addr (rd_addr),
      .rd_data (norm_rd)
   );

   lkt_ram #(.WIDTH(lkt_pkg::CODE_W), .DEPTH(KEY_COUNT)) u_sym_ram (
      .clock   (clock),
      .wr_en   (sym_wr),
      .wr_addr (q_idx),
      .wr_data (q_cmd.code),
      .rd_addr (rd_addr),
      .rd_data (sym_rd)
   );

   // Entries never loaded since reset read as reserved
   assign norm_code = norm_vld_ff[cur_idx_ff] ? norm_rd : '0;
   assign sym_code  = sym_vld_ff[cur_idx_ff]  ? sym_rd  : '0;

   // Pick the reporting layer and decide on a release of the other one
   always_comb begin
      if (cur_layer_ff) begin
         main_code   = sym_code;
         other_code  = norm_code;
         pre_release = !mark_ff[cur_idx_ff] && norm_code != '0;
      end else begin
         main_code   = norm_code;
         other_code  = sym_code;
         pre_release = mark_ff[cur_idx_ff] && sym_code != '0;
      end
      active = main_code != '0;
   end

   // Sequence: read maps, emit up to two words, then take the next command
   always_comb begin
      st_in          = st_ff;
      cur_idx_in     = cur_idx_ff;
      cur_pressed_in = cur_pressed_ff;
      cur_layer_in   = cur_layer_ff;
      pend_in        = pend_ff;
      out_in         = out_ff;
      out_vld_in     = out_vld_ff && !rsp_if.ready;
      free           = 1'b0;
      emit           = 1'b0;
      mark_wr        = 1'b0;
      norm_wr        = 1'b0;
      sym_wr         = 1'b0;

      case (st_ff)
         ST_IDLE: begin
            free = 1'b1;
         end
         ST_DATA: begin
            if (!active) begin
               free = 1'b1;
            end else if (can_emit) begin
               emit    = 1'b1;
               mark_wr = 1'b1;
               if (pre_release) begin
                  out_in  = '{kind: lkt_pkg::EV_KEY, code: other_code, value: 1'b0,
                              last: 1'b0};
                  pend_in = '{kind: lkt_pkg::EV_KEY, code: main_code,
                              value: cur_pressed_ff, last: 1'b1};
                  st_in   = ST_SECOND;
               end else begin
                  out_in = '{kind: lkt_pkg::EV_KEY, code: main_code,
                             value: cur_pressed_ff, last: 1'b1};
                  free   = 1'b1;
               end
            end
         end
         ST_SECOND: begin
            if (can_emit) begin
               emit   = 1'b1;
               out_in = pend_ff;
               free   = 1'b1;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase

      if (free) begin
         st_in = ST_IDLE;
      end

      q_pop = q_valid && free;

      if (q_pop) begin
         case (q_cmd.kind)
            lkt_pkg::CMD_KEY: begin
               cur_idx_in     = q_idx;
               cur_pressed_in = q_cmd.value;
               cur_layer_in   = q_cmd.layer;
               st_in          = ST_DATA;
            end
            lkt_pkg::CMD_SWITCH: begin
               pend_in = '{kind: lkt_pkg::EV_SWITCH, code: q_cmd.code,
                           value: q_cmd.value, last: 1'b1};
               st_in   = ST_SECOND;
            end
            lkt_pkg::CMD_LOAD_NORMAL: begin
               norm_wr = 1'b1;
            end
            lkt_pkg::CMD_LOAD_SYMBOL: begin
               sym_wr = 1'b1;
            end
            default: ;
         endcase
      end

      if (emit) begin
         out_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= ST_IDLE;
         out_vld_ff  <= 1'b0;
         norm_vld_ff <= '0;
         sym_vld_ff  <= '0;
         mark_ff     <= '0;
      end else begin
         st_ff      <= st_in;
         out_vld_ff <= out_vld_in;
         if (norm_wr) norm_vld_ff[q_idx] <= 1'b1;
         if (sym_wr)  sym_vld_ff[q_idx]  <= 1'b1;
         if (mark_wr) mark_ff[cur_idx_ff] <= cur_layer_ff && cur_pressed_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_idx_ff     <= cur_idx_in;
      cur_pressed_ff <= cur_pressed_in;
      cur_layer_ff   <= cur_layer_in;
      pend_ff        <= pend_in;
      out_ff         <= out_in;
   end

   assign rsp_if.valid       = out_vld_ff;
   assign rsp_if.event_kind  = out_ff.kind;
   assign rsp_if.event_code  = out_ff.code;
   assign rsp_if.event_value = out_ff.value;
   assign rsp_if.last        = out_ff.last;

   // A word that is not last is always followed by the second word
   a_first_then_second: assert property (@(posedge clock) disable iff (reset)
      (emit && !out_in.last) |=> st_ff == ST_SECOND)
      else $error("non-last word not followed by second word");

   // Key events never carry the reserved code
   a_key_code_nonzero: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_ff.kind == lkt_pkg::EV_KEY) |-> out_ff.code != '0)
      else $error("key event with reserved code");

   // Switch events carry only lid, tablet or dock
   a_switch_id: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_ff.kind == lkt_pkg::EV_SWITCH) |->
         (out_ff.code == lkt_pkg::SWID_LID || out_ff.code == lkt_pkg::SWID_TABLET ||
          out_ff.code == lkt_pkg::SWID_DOCK))
      else $error("switch event with bad id");

   // The pending word is always the closing one
   a_pend_last: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_SECOND |-> pend_ff.last)
      else $error("pending word not marked last");

   // A popped key command is read out in the next cycle
   a_key_read: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_cmd.kind == lkt_pkg::CMD_KEY) |=>
         (st_ff == ST_DATA && cur_idx_ff == $past(q_idx)))
      else $error("key command not read");

endmodule

@@ src/layered_keycode_translator.sv @@
`timescale 1ns / 1ps

// Layered keycode translator: raw keyboard-controller bytes in, key and
// switch events out.
// req_if carries one word per item: operation selects a raw byte or a load
// of a normal or symbol map entry (map_index, map_code). rsp_if delivers
// events (event_kind, event_code, event_value) with last set on the final
// event of each byte; loads and bytes that map to nothing give no event.
// csr_if writes the symbol key index; write it only while the block is idle.
// A byte's command is registered in the queue entry, then in the map read
// and the back state, and its first event then in the output register. The
// front takes a word every cycle while its two-entry queue has room. A byte
// that also releases the other layer's code leaves as two words, from ST_DATA
// and then ST_SECOND; that back sequencer, bound by the registered map read,
// sets the sustained rate.
// Reset clears the queue, the output register, the symbol mode, the lid flag
// and the layer marks, and the maps read as zero through per-entry valid
// bits, so the block takes words in the first cycle after reset. When the
// receiver stalls, the output word holds, the back stops and the queue fills,
// after which req_if.ready drops.
module layered_keycode_translator #(
   parameter int KEY_COUNT = lkt_pkg::KEY_COUNT
) (
   input  logic       clock,
   input  logic       reset,
   lkt_req_if.sink    req_if,
   lkt_rsp_if.source  rsp_if,
   lkt_csr_if.sink    csr_if
);

   logic              push, push_ready, pop, pop_valid;
   lkt_pkg::cmd_type  push_cmd, pop_cmd;

   lkt_front #(.KEY_COUNT(KEY_COUNT)) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .csr_if  (csr_if),
      .q_ready (push_ready),
      .q_push  (push),
      .q_cmd   (push_cmd)
   );

   lkt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd)
   );

   lkt_back #(.KEY_COUNT(KEY_COUNT)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (pop_valid),
      .q_cmd   (pop_cmd),
      .q_pop   (pop),
      .rsp_if  (rsp_if)
   );

endmodule

@@ verif/layered_keycode_translator_tb.sv @@
`timescale 1ns / 1ps

module layered_keycode_translator_tb;

   localparam int                        TIMEOUT_NS   = 5_000_000;
   localparam int                        SETTLE       = 12;
   localparam int                        HOLD_CYCLES  = 200;
   localparam int                        PHASE_WORDS  = 375;
   localparam int                        PREDICTED    = -1;
   localparam logic [lkt_pkg::OP_W-1:0]  OP_RESERVED  = 2'd3;

   // One input word plus the events typed in for it (fixed_n = PREDICTED: none)
   typedef struct {
      logic [lkt_pkg::OP_W-1:0]   op;
      logic [lkt_pkg::BYTE_W-1:0] kb;
      logic [lkt_pkg::IDX_W-1:0]  idx;
      logic [lkt_pkg::CODE_W-1:0] code;
      int                         fixed_n;
      lkt_pkg::event_type         fixed_ev [2];
   } key_word_type;

   logic clock = 1'b0;
   logic reset;

   lkt_req_if req_if ();
   lkt_rsp_if rsp_if ();
   lkt_csr_if csr_if ();

   layered_keycode_translator uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source),
      .csr_if (csr_if.sink)
   );

   // Translator state as the checker sees it
   logic [lkt_pkg::CODE_W-1:0] normal_codes [lkt_pkg::KEY_COUNT] = '{default: '0};
   logic [lkt_pkg::CODE_W-1:0] symbol_codes [lkt_pkg::KEY_COUNT] = '{default: '0};
   logic                       symbol_held  [lkt_pkg::KEY_COUNT] = '{default: 1'b0};
   logic                       layer_on     = 1'b0;
   logic                       lid_closing  = 1'b0;
   logic [lkt_pkg::IDX_W-1:0]  layer_key    = lkt_pkg::SYM_KEY_RESET;

   lkt_pkg::event_type events_due [$];
   key_word_type       cur_word;
   key_word_type       table_rows [$];

   int mismatches     = 0;
   int words_taken    = 0;
   int events_checked = 0;
   int key_settings   = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;
   bit hold_request   = 1'b0;
   int hot_base       = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic lkt_pkg::event_type mk_event(input logic k,
                                                   input logic [lkt_pkg::CODE_W-1:0] c,
                                                   input logic v, input logic l);
      lkt_pkg::event_type e;
      e.kind  = k;
      e.code  = c;
      e.value = v;
      e.last  = l;
      return e;
   endfunction

   function automatic logic [lkt_pkg::BYTE_W-1:0] sw_byte(input logic [lkt_pkg::SW_W-1:0] sw,
                                                          input logic on);
      return {1'b1, 1'b0, sw, ~on};
   endfunction

   function automatic logic [lkt_pkg::BYTE_W-1:0] key_byte(input logic [lkt_pkg::IDX_W-1:0] k,
                                                           input logic released);
      return {1'b0, released, k};
   endfunction

   function automatic key_word_type row(input logic [lkt_pkg::OP_W-1:0] op,
                                        input logic [lkt_pkg::BYTE_W-1:0] kb,
                                        input logic [lkt_pkg::IDX_W-1:0] idx,
                                        input logic [lkt_pkg::CODE_W-1:0] code, input int n,
                                        input lkt_pkg::event_type e0 = '0,
                                        input lkt_pkg::event_type e1 = '0);
      key_word_type w;
      w.op          = op;
      w.kb          = kb;
      w.idx         = idx;
      w.code        = code;
      w.fixed_n     = n;
      w.fixed_ev[0] = e0;
      w.fixed_ev[1] = e1;
      return w;
   endfunction

   // Translate one word into its events and advance the tracked state
   function automatic int translate_word(input key_word_type w,
                                         output lkt_pkg::event_type out_ev [2]);
      logic [lkt_pkg::SW_W-1:0]  sw;
      logic                      on;
      logic                      pressed;
      logic [lkt_pkg::IDX_W-1:0] k;
      int                        n;
      n = 0;
      out_ev[0] = '0;
      out_ev[1] = '0;
      case (w.op)
         lkt_pkg::OP_LOAD_NORMAL: normal_codes[w.idx] = w.code;
         lkt_pkg::OP_LOAD_SYMBOL: symbol_codes[w.idx] = w.code;
         lkt_pkg::OP_KEY: begin
            if (w.kb[lkt_pkg::BIT_SWITCH]) begin
               sw = w.kb[5:1];
               on = ~w.kb[0];
               if (sw == lkt_pkg::SW_LID_OPEN) begin
                  if (!on) lid_closing = 1'b0;
               end else if (sw == lkt_pkg::SW_LID_CLOSE) begin
                  if (on) lid_closing = 1'b1;
               end else if (sw == lkt_pkg::SW_LID_TABLET) begin
                  out_ev[n] = mk_event(lkt_pkg::EV_SWITCH,
                                       lid_closing ? lkt_pkg::SWID_LID : lkt_pkg::SWID_TABLET,
                                       on, 1'b0);
                  n++;
               end else if (sw == lkt_pkg::SW_DOCK) begin
                  out_ev[n] = mk_event(lkt_pkg::EV_SWITCH, lkt_pkg::SWID_DOCK, on, 1'b0);
                  n++;
               end
            end else begin
               k       = w.kb[lkt_pkg::IDX_W-1:0];
               pressed = ~w.kb[lkt_pkg::BIT_RELEASE];
               if (k == layer_key) begin
                  layer_on = pressed;
               end else if (layer_on) begin
                  // symbol layer: drop the normal code first unless already held there
                  if (symbol_codes[k] != '0) begin
                     if (!symbol_held[k] && normal_codes[k] != '0) begin
                        out_ev[n] = mk_event(lkt_pkg::EV_KEY, normal_codes[k], 1'b0, 1'b0);
                        n++;
                     end
                     out_ev[n] = mk_event(lkt_pkg::EV_KEY, symbol_codes[k], pressed, 1'b0);
                     n++;
                     symbol_held[k] = pressed;
                  end
               end else if (normal_codes[k] != '0) begin
                  if (symbol_held[k] && symbol_codes[k] != '0) begin
                     out_ev[n] = mk_event(lkt_pkg::EV_KEY, symbol_codes[k], 1'b0, 1'b0);
                     n++;
                  end
                  out_ev[n] = mk_event(lkt_pkg::EV_KEY, normal_codes[k], pressed, 1'b0);
                  n++;
                  symbol_held[k] = 1'b0;
               end
            end
         end
         default: ;
      endcase
      if (n > 0) out_ev[n-1].last = 1'b1;
      return n;
   endfunction

   function automatic void flag_mismatch(input string what, input lkt_pkg::event_type want,
                                         input lkt_pkg::event_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s: expected kind/code/value/last %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                  $realtime, what, want.kind, want.code, want.value, want.last,
                  got.kind, got.code, got.value, got.last);
   endfunction

   // Check results, predict accepted words, track the symbol key
   always @(posedge clock) begin
      lkt_pkg::event_type got;
      lkt_pkg::event_type want;
      lkt_pkg::event_type pred [2];
      int                 n;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = mk_event(rsp_if.event_kind, rsp_if.event_code, rsp_if.event_value,
                           rsp_if.last);
            events_checked++;
            if (events_due.size() == 0) begin
               flag_mismatch("event with nothing due", '0, got);
            end else begin
               want = events_due.pop_front();
               if (got.kind !== want.kind || got.code !== want.code ||
                   got.value !== want.value || got.last !== want.last)
                  flag_mismatch("event", want, got);
            end
         end
         if (req_if.valid && req_if.ready) begin
            words_taken++;
            n = translate_word(cur_word, pred);
            if (cur_word.fixed_n != PREDICTED) begin
               if (n != cur_word.fixed_n) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: table row expects %0d events, predictor gives %0d",
                              $realtime, cur_word.fixed_n, n);
               end else begin
                  for (int i = 0; i < n; i++)
                     if (pred[i] !== cur_word.fixed_ev[i])
                        flag_mismatch("table row", cur_word.fixed_ev[i], pred[i]);
               end
            end
            for (int i = 0; i < n; i++)
               events_due.push_back(pred[i]);
         end
         if (csr_if.valid && csr_if.ready) begin
            layer_key = csr_if.data;
            key_settings++;
         end
      end
   end

   // Drive result ready: random stalls, plus one long hold on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left--;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offer one word, called at a falling edge; returns at the falling edge after the word is taken
   task automatic send_word(input key_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      cur_word = w;
      req_if.valid     <= 1'b1;
      req_if.operation <= w.op;
      req_if.key_byte  <= w.kb;
      req_if.map_index <= w.idx;
      req_if.map_code  <= w.code;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // Stop offering and wait until every due event is out and the pipe is empty
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (events_due.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_layer_key(input logic [lkt_pkg::IDX_W-1:0] k);
      csr_if.valid <= 1'b1;
      csr_if.data  <= k;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Mostly the symbol key and a small cluster of hot keys, sometimes any key
   function automatic logic [lkt_pkg::IDX_W-1:0] pick_key();
      int r;
      r = $urandom_range(9);
      if (r < 2) return layer_key;
      if (r < 8) return (lkt_pkg::IDX_W)'(hot_base + $urandom_range(5));
      return (lkt_pkg::IDX_W)'($urandom_range(lkt_pkg::KEY_COUNT - 1));
   endfunction

   function automatic key_word_type random_word();
      key_word_type w;
      int           pick;
      w = row(lkt_pkg::OP_KEY, (lkt_pkg::BYTE_W)'($urandom), (lkt_pkg::IDX_W)'($urandom),
              (lkt_pkg::CODE_W)'($urandom), PREDICTED);
      pick = $urandom_range(99);
      if (pick < 4) begin
         w.op = OP_RESERVED;
      end else if (pick < 16) begin
         w.op  = pick[0] ? lkt_pkg::OP_LOAD_NORMAL : lkt_pkg::OP_LOAD_SYMBOL;
         w.idx = pick_key();
         if ($urandom_range(9) == 0) w.code = '0;
      end else if (pick < 30) begin
         case ($urandom_range(4))
            0:       w.kb[5:1] = lkt_pkg::SW_LID_OPEN;
            1:       w.kb[5:1] = lkt_pkg::SW_DOCK;
            2:       w.kb[5:1] = lkt_pkg::SW_LID_TABLET;
            3:       w.kb[5:1] = lkt_pkg::SW_LID_CLOSE;
            default: ;
         endcase
         w.kb[lkt_pkg::BIT_SWITCH] = 1'b1;
      end else begin
         w.kb = key_byte(pick_key(), 1'($urandom_range(1)));
      end
      return w;
   endfunction

   initial begin
      logic [lkt_pkg::IDX_W-1:0] phase_key [4];
      int                        phase_send [4];
      int                        phase_recv [4];
      key_word_type              w;
      phase_key  = '{6'd0, 6'd63, (lkt_pkg::IDX_W)'($urandom_range(62) + 1),
                     lkt_pkg::SYM_KEY_RESET};
      phase_send = '{0, 53, 0, 17};
      phase_recv = '{0, 0, 53, 17};

      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.operation = lkt_pkg::OP_KEY;
      req_if.key_byte  = '0;
      req_if.map_index = '0;
      req_if.map_code  = '0;
      rsp_if.ready     = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.data      = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words: switches, lid tracking, layer changes, empty entries
      table_rows.push_back(row(lkt_pkg::OP_KEY, key_byte(0, 0), 0, 0, 0));
      table_rows.push_back(row(lkt_pkg::OP_KEY, sw_byte(lkt_pkg::SW_LID_TABLET, 1), 0, 0, 1,
                               mk_event(lkt_pkg::EV_SWITCH, lkt_pkg::SWID_TABLET, 1, 1)));
      table_rows.push_back(row(lkt_pkg::OP_KEY, sw_byte(lkt_pkg::SW_DOCK, 1), 0, 0, 1,
                               mk_event(lkt_pkg::EV_SWITCH, lkt_pkg::SWID_DOCK, 1, 1)));
      table_rows.push_back(row(lkt_pkg::OP_KEY, sw_byte(lkt_pkg::SW_DOCK, 0), 0, 0, 1,
                               mk_event(lkt_pkg::EV_SWITCH, lkt_pkg::SWID_DOCK, 0, 1)));
      table_rows.push_back(row(lkt_pkg::OP_KEY, sw_byte(lkt_pkg::SW_LID_CLOSE, 1), 0, 0, 0));
      table_rows.push_back(row(lkt_pkg::OP_KEY, sw_byte(lkt_pkg::SW_LID_TABLET, 1), 0, 0, 1,
                               mk_event(lkt_pkg::EV_SWITCH, lkt_pkg::SWID_LID, 1, 1)));
      table_rows.push_back(row(lkt_pkg::OP_KEY, sw_byte(lkt_pkg::SW_LID_OPEN, 1), 0, 0, 0));
      table_rows.push_back(row(lkt_pkg::OP_KEY, sw_byte(lkt_pkg::SW_LID_CLOSE, 0), 0, 0, 0));
      table_rows.push_back(row(lkt_pkg::OP_KEY, sw_byte(lkt_pkg::SW_LID_TABLET, 0), 0, 0, 1,
                               mk_event(lkt_pkg::EV_SWITCH, lkt_pkg::SWID_LID, 0, 1)));
      table_rows.push_back(row(lkt_pkg::OP_KEY, sw_byte(lkt_pkg::SW_LID_OPEN, 0), 0, 0, 0));
      table_rows.push_back(row(lkt_pkg::OP_KEY, sw_byte(lkt_pkg::SW_LID_TABLET, 0), 0, 0, 1,
                               mk_event(lkt_pkg::EV_SWITCH, lkt_pkg::SWID_TABLET, 0, 1)));
      table_rows.push_back(row(lkt_pkg::OP_KEY, 8'hFF, 0, 0, 0));
      table_rows.push_back(row(OP_RESERVED, sw_byte(lkt_pkg::SW_DOCK, 1), 63, 1023, 0));
      table_rows.push_back(row(lkt_pkg::OP_LOAD_NORMAL, 8'hFF, 0, 1023, 0));
      table_rows.push_back(row(lkt_pkg::OP_KEY, key_byte(0, 0), 0, 0, 1,
                               mk_event(lkt_pkg::EV_KEY, 1023, 1, 1)));
      table_rows.push_back(row(lkt_pkg::OP_KEY, key_byte(0, 1), 0, 0, 1,
                               mk_event(lkt_pkg::EV_KEY, 1023, 0, 1)));
      table_rows.push_back(row(lkt_pkg::OP_LOAD_SYMBOL, 8'h00, 63, 1, 0));
      table_rows.push_back(row(lkt_pkg::OP_LOAD_NORMAL, 8'h00, 63, 5, 0));
      table_rows.push_back(row(lkt_pkg::OP_KEY, key_byte(lkt_pkg::SYM_KEY_RESET, 0), 0, 0, 0));
      table_rows.push_back(row(lkt_pkg::OP_KEY, key_byte(63, 0), 0, 0, 2,
                               mk_event(lkt_pkg::EV_KEY, 5, 0, 0),
                               mk_event(lkt_pkg::EV_KEY, 1, 1, 1)));
      table_rows.push_back(row(lkt_pkg::OP_KEY, key_byte(lkt_pkg::SYM_KEY_RESET, 1), 0, 0, 0));
      table_rows.push_back(row(lkt_pkg::OP_KEY, key_byte(63, 1), 0, 0, 2,
                               mk_event(lkt_pkg::EV_KEY, 1, 0, 0),
                               mk_event(lkt_pkg::EV_KEY, 5, 0, 1)));
      // symbol entry only: the release of the empty normal code is skipped
      table_rows.push_back(row(lkt_pkg::OP_LOAD_SYMBOL, 8'h00, 1, 700, PREDICTED));
      table_rows.push_back(row(lkt_pkg::OP_KEY, key_byte(lkt_pkg::SYM_KEY_RESET, 0), 0, 0,
                               PREDICTED));
      table_rows.push_back(row(lkt_pkg::OP_KEY, key_byte(1, 0), 0, 0, PREDICTED));
      table_rows.push_back(row(lkt_pkg::OP_KEY, key_byte(0, 0), 0, 0, PREDICTED));
      table_rows.push_back(row(lkt_pkg::OP_KEY, key_byte(lkt_pkg::SYM_KEY_RESET, 1), 0, 0,
                               PREDICTED));
      table_rows.push_back(row(lkt_pkg::OP_KEY, key_byte(1, 1), 0, 0, PREDICTED));
      foreach (table_rows[i])
         send_word(table_rows[i]);
      wait_idle();

      // Random phases, each with its own symbol key and idle mix
      for (int p = 0; p < 4; p++) begin
         write_layer_key(phase_key[p]);
         send_idle_pct  = phase_send[p];
         recv_stall_pct = phase_recv[p];
         hot_base       = $urandom_range(lkt_pkg::KEY_COUNT - 6);
         if (p == 0) begin
            // fill both maps so most keys translate
            for (int i = 0; i < 2 * lkt_pkg::KEY_COUNT; i++) begin
               w = row(i < lkt_pkg::KEY_COUNT ? lkt_pkg::OP_LOAD_NORMAL
                                              : lkt_pkg::OP_LOAD_SYMBOL,
                       (lkt_pkg::BYTE_W)'($urandom), (lkt_pkg::IDX_W)'(i),
                       ($urandom_range(7) == 0) ? '0 : (lkt_pkg::CODE_W)'($urandom),
                       PREDICTED);
               send_word(w);
            end
         end
         for (int i = 0; i < PHASE_WORDS; i++) begin
            if (p == 0 && i == 100) hold_request = 1'b1;
            send_word(random_word());
         end
         wait_idle();
      end

      $display("%0d words taken (%0d from the table), %0d events checked",
               words_taken, table_rows.size(), events_checked);
      $display("%0d symbol key settings, four idle mixes, one %0d-cycle result hold",
               key_settings, HOLD_CYCLES);
      if (mismatches == 0 && events_due.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d events still due", events_due.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule
